FILE: rtl/hct_pkg.sv
// ----------------------------------------------------------------------------
// Huffman code tree package
// Shared widths, operation and status codes, node layout and the structs
// passed between the tree sequencer and its level evaluation unit.
// ----------------------------------------------------------------------------
package hct_pkg;

  // Table geometry.
  localparam int MAX_NODES    = 1024;
  localparam int IDX_W        = $clog2(MAX_NODES);
  localparam int CNT_W        = $clog2(MAX_NODES + 1);
  localparam int MAX_CODE_LEN = 15;

  // Fixed field widths.
  localparam int OP_W   = 3;
  localparam int CODE_W = 15;
  localparam int LEN_W  = 4;
  localparam int SYM_W  = 9;
  localparam int ST_W   = 3;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT     = 3'd0;
  localparam logic [OP_W-1:0] OP_FIND       = 3'd1;
  localparam logic [OP_W-1:0] OP_STEP       = 3'd2;
  localparam logic [OP_W-1:0] OP_CURSOR_RST = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_PREFIX   = 3'd1;
  localparam logic [ST_W-1:0] ST_NOBRANCH = 3'd2;
  localparam logic [ST_W-1:0] ST_PRESENT  = 3'd3;
  localparam logic [ST_W-1:0] ST_THRULEAF = 3'd4;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd5;

  // Kind of tree walk in progress.
  typedef enum logic [1:0] {
    MODE_INSERT,
    MODE_FIND,
    MODE_STEP
  } mode_t;

  // One node of the table. A child index of zero means no child.
  typedef struct packed {
    idx_t             kid_l;
    idx_t             kid_r;
    logic             leaf;
    logic [SYM_W-1:0] sym;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  // What the sequencer does after one level has been evaluated.
  typedef enum logic [1:0] {
    ACT_NEXT,
    ACT_NEW,
    ACT_END
  } act_t;

  // Request to the level unit.
  typedef struct packed {
    node_t            node;
    logic             cbit;
    logic [LEN_W-1:0] rem;
    mode_t            mode;
    cnt_t             count;
    logic [SYM_W-1:0] sym;
  } lvl_req_t;

  // Answer from the level unit.
  typedef struct packed {
    act_t            act;
    logic [ST_W-1:0] status;
    idx_t            child;
    node_t           linked;
    node_t           fresh;
  } lvl_res_t;

endpackage

FILE: rtl/hct_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data; no reset.
// ----------------------------------------------------------------------------
module hct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write when enabled; read every cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/hct_level.sv
// ----------------------------------------------------------------------------
// Huffman code tree level unit
// Evaluates one tree level for the current node and code bit: picks the
// child, decides whether to descend, create a node or finish, and builds the
// updated parent word and the word of a newly made node.
// ----------------------------------------------------------------------------
module hct_level
  import hct_pkg::*;
(
  input  lvl_req_t req,
  output lvl_res_t res
);

  logic last;
  logic full;
  idx_t child;
  idx_t new_idx;

  assign last    = (req.rem == LEN_W'(1));
  assign full    = (req.count >= CNT_W'(MAX_NODES));
  assign child   = req.cbit ? req.node.kid_r : req.node.kid_l;
  assign new_idx = req.count[IDX_W-1:0];

  // Parent word with the new link, the word of the node being created, and
  // the decision for this level.
  always_comb begin
    res.child  = child;
    res.linked = req.node;
    if (req.cbit) begin
      res.linked.kid_r = new_idx;
    end else begin
      res.linked.kid_l = new_idx;
    end
    res.fresh.kid_l = '0;
    res.fresh.kid_r = '0;
    res.fresh.leaf  = last;
    res.fresh.sym   = last ? req.sym : '0;

    res.act    = ACT_END;
    res.status = ST_OK;
    if (req.rem == '0) begin
      // The walk has consumed every bit: classify the node reached.
      if (req.node.leaf) begin
        res.status = ST_OK;
      end else if (req.mode == MODE_INSERT) begin
        res.status = ST_PRESENT;
      end else begin
        res.status = ST_PREFIX;
      end
    end else if (req.mode == MODE_INSERT) begin
      if (req.node.leaf) begin
        res.status = ST_THRULEAF;
      end else if (child != '0) begin
        if (last) begin
          res.status = ST_PRESENT;
        end else begin
          res.act = ACT_NEXT;
        end
      end else if (full) begin
        res.status = ST_FULL;
      end else begin
        res.act = ACT_NEW;
      end
    end else begin
      if (child == '0) begin
        res.status = ST_NOBRANCH;
      end else begin
        res.act = ACT_NEXT;
      end
    end
  end

endmodule

FILE: rtl/huffman_code_tree_core.sv
// Insert and find walk the tree from the root and a single-bit step walks one level from the
// cursor; reset cursor, clear tree and unused codes need no walk. Each ends with a done strobe.
// Throughput: busy stays high while a walk is in progress, and no new start is taken then;
// the node table is walked one level per cycle through its single registered read port.
// Reset: synchronous; the tree holds only the empty root and the cursor is at the root.
// Table entries at or above the fill count are never used, so there is no clearing pass.
// ----------------------------------------------------------------------------
// Huffman code tree core
// Holds a binary code tree in a node table and inserts codes, looks up whole
// codes and steps a bit-serial decode cursor, one tree level per cycle.
// ----------------------------------------------------------------------------
module huffman_code_tree_core
  import hct_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   operation,
  input  logic [CODE_W-1:0] code_bits,
  input  logic [LEN_W-1:0]  code_length,
  input  logic [SYM_W-1:0]  symbol,
  input  logic              bit_req,
  output logic              done,
  output logic [ST_W-1:0]   status,
  output logic [SYM_W-1:0]  found_symbol
);

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

  state_t           state;
  mode_t            mode;
  logic [CODE_W-1:0] code_q;
  logic [LEN_W-1:0] rem;
  logic [SYM_W-1:0] sym_q;
  idx_t             cur;
  node_t            cur_word;
  logic             use_rd;
  logic             fresh;
  logic             linked;
  idx_t             link_parent;
  logic             link_bit;
  node_t            link_word;
  cnt_t             start_count;
  cnt_t             node_count;
  idx_t             cursor;
  idx_t             root_l;
  idx_t             root_r;

  logic [LEN_W-1:0]  len_sat;
  logic [LEN_W-1:0]  rem_m1;
  logic [CODE_W:0]   code_ext;
  node_t             root_word;
  node_t             node_word;
  lvl_req_t          req;
  lvl_res_t          res;
  logic [NODE_W-1:0] rd_data;
  idx_t              rd_addr;
  logic              we;
  idx_t              waddr;
  node_t             wdata;

  assign busy = (state == S_WALK);

  // Code lengths above the supported maximum are saturated.
  assign len_sat = (code_length > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : code_length;

  // The bit consumed at this level sits at position rem - 1.
  assign rem_m1   = rem - 1'b1;
  assign code_ext = {1'b0, code_q};

  // The root lives in registers and is never a leaf.
  always_comb begin
    root_word.kid_l = root_l;
    root_word.kid_r = root_r;
    root_word.leaf  = 1'b0;
    root_word.sym   = '0;
  end

  // Current node: the root, the word just read, or a node not yet written.
  always_comb begin
    if (cur == '0) begin
      node_word = root_word;
    end else if (use_rd) begin
      node_word = node_t'(rd_data);
    end else begin
      node_word = cur_word;
    end
  end

  // Level evaluation request.
  always_comb begin
    req.node  = node_word;
    req.cbit  = (rem != '0) ? code_ext[rem_m1] : 1'b0;
    req.rem   = rem;
    req.mode  = mode;
    req.count = node_count;
    req.sym   = sym_q;
  end

  hct_level u_level (
    .req (req),
    .res (res)
  );

  // Read address: the cursor node when idle, the chosen child while walking.
  assign rd_addr = (state == S_WALK) ? res.child : cursor;

  // Table writes: link a new child, store a finished leaf, or undo the
  // first link of an insert that ran out of nodes.
  always_comb begin
    we    = 1'b0;
    waddr = cur;
    wdata = res.linked;
    if (state == S_WALK) begin
      if (res.act == ACT_NEW && cur != '0) begin
        we = 1'b1;
      end else if (res.act == ACT_END && mode == MODE_INSERT) begin
        if (res.status == ST_FULL && linked && link_parent != '0) begin
          we    = 1'b1;
          waddr = link_parent;
          wdata = link_word;
        end else if (res.status == ST_OK && fresh) begin
          we    = 1'b1;
          wdata = cur_word;
        end
      end
    end
  end

  hct_ram #(
    .WIDTH (NODE_W),
    .DEPTH (MAX_NODES)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Sequencer, tree bookkeeping and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      node_count <= CNT_W'(1);
      cursor     <= '0;
      root_l     <= '0;
      root_r     <= '0;
      linked     <= 1'b0;
      fresh      <= 1'b0;
      use_rd     <= 1'b0;
      cur        <= '0;
      rem        <= '0;
      mode       <= MODE_FIND;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            case (operation)
              OP_INSERT, OP_FIND: begin
                mode        <= (operation == OP_INSERT) ? MODE_INSERT : MODE_FIND;
                code_q      <= code_bits;
                rem         <= len_sat;
                sym_q       <= symbol;
                cur         <= '0;
                use_rd      <= 1'b0;
                fresh       <= 1'b0;
                linked      <= 1'b0;
                start_count <= node_count;
                state       <= S_WALK;
              end
              OP_STEP: begin
                mode   <= MODE_STEP;
                code_q <= CODE_W'(bit_req);
                rem    <= LEN_W'(1);
                sym_q  <= '0;
                cur    <= cursor;
                use_rd <= 1'b1;
                fresh  <= 1'b0;
                linked <= 1'b0;
                state  <= S_WALK;
              end
              OP_CURSOR_RST: begin
                cursor       <= '0;
                done         <= 1'b1;
                status       <= ST_OK;
                found_symbol <= '0;
              end
              OP_CLEAR: begin
                root_l       <= '0;
                root_r       <= '0;
                node_count   <= CNT_W'(1);
                cursor       <= '0;
                done         <= 1'b1;
                status       <= ST_OK;
                found_symbol <= '0;
              end
              default: begin
                done         <= 1'b1;
                status       <= ST_NOBRANCH;
                found_symbol <= '0;
              end
            endcase
          end
        end

        S_WALK: begin
          unique case (res.act)
            ACT_NEXT: begin
              // Descend to an existing child; its word arrives next cycle.
              cur    <= res.child;
              use_rd <= 1'b1;
              fresh  <= 1'b0;
              rem    <= rem - 1'b1;
            end
            ACT_NEW: begin
              // Allocate a node; it is written when the walk moves past it.
              if (cur == '0) begin
                if (req.cbit) begin
                  root_r <= node_count[IDX_W-1:0];
                end else begin
                  root_l <= node_count[IDX_W-1:0];
                end
              end
              if (!linked) begin
                linked      <= 1'b1;
                link_parent <= cur;
                link_bit    <= req.cbit;
                link_word   <= node_word;
              end
              node_count <= node_count + 1'b1;
              cur        <= node_count[IDX_W-1:0];
              cur_word   <= res.fresh;
              use_rd     <= 1'b0;
              fresh      <= 1'b1;
              rem        <= rem - 1'b1;
            end
            default: begin
              done         <= 1'b1;
              status       <= res.status;
              found_symbol <= (res.status == ST_OK) ? node_word.sym : '0;
              state        <= S_IDLE;
              // A full table drops every node this insert made.
              if (mode == MODE_INSERT && res.status == ST_FULL) begin
                node_count <= start_count;
                if (linked && link_parent == '0) begin
                  if (link_bit) begin
                    root_r <= '0;
                  end else begin
                    root_l <= '0;
                  end
                end
              end
              // A step that finds a branch leaves the cursor on the node reached.
              if (mode == MODE_STEP && rem == '0) begin
                cursor <= cur;
              end
            end
          endcase
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // The fill count always covers the root and never passes the table size.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    node_count >= CNT_W'(1) && node_count <= CNT_W'(MAX_NODES))
    else $error("node count out of range");

  // The cursor only ever rests on an allocated node.
  a_cursor_alloc: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(cursor) < node_count)
    else $error("cursor points past the allocated nodes");

  // Table writes never touch the root slot or an unallocated entry.
  a_write_addr: assert property (@(posedge clk) disable iff (rst)
    we |-> (waddr != '0 && CNT_W'(waddr) < node_count))
    else $error("table write to an illegal entry");

  // Every result follows an accepted transaction or the end of a walk.
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result strobe without a transaction");

  // A symbol is reported only with an ok status.
  a_sym_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> found_symbol == '0)
    else $error("symbol reported with a non-ok status");
`endif

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Huffman code tree core testbench
// Drives insert, find, step, cursor reset and clear transactions into the
// core, predicts every result with a behavioral copy of the node table, and
// compares each done strobe with the oldest predicted result. A short table
// of directed transactions comes first, then rounds of random tree builds,
// lookups and bit-serial decode walks under three sender idling profiles.
// ----------------------------------------------------------------------------
module testbench;
  import hct_pkg::*;

  // Operation codes the core treats as no-ops.
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

  localparam int RANDOM_ITEMS = 1750;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [CODE_W-1:0] bits;
    logic [LEN_W-1:0]  len;
    logic [SYM_W-1:0]  sym;
    logic              b;
    bit                typed;
    logic [ST_W-1:0]   ex_st;
    logic [SYM_W-1:0]  ex_fs;
  } tree_cmd_t;

  typedef struct {
    logic [ST_W-1:0]  st;
    logic [SYM_W-1:0] fs;
  } tree_result_t;

  typedef struct {
    logic [CODE_W-1:0] bits;
    logic [LEN_W-1:0]  len;
  } code_entry_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [OP_W-1:0]   operation;
  logic [CODE_W-1:0] code_bits;
  logic [LEN_W-1:0]  code_length;
  logic [SYM_W-1:0]  symbol;
  logic              bit_req;
  logic              done;
  logic [ST_W-1:0]   status;
  logic [SYM_W-1:0]  found_symbol;

  // Behavioral copy of the node table and decode cursor.
  idx_t             tree_l    [MAX_NODES];
  idx_t             tree_r    [MAX_NODES];
  logic [SYM_W-1:0] tree_sym  [MAX_NODES];
  logic             tree_leaf [MAX_NODES];
  cnt_t             tree_fill;
  idx_t             decode_pos;

  tree_result_t pending_results[$];
  code_entry_t  known_codes[$];
  tree_cmd_t    directed_rows[$];
  int           errors;
  int           sent_count;
  int           idle_pct;

  huffman_code_tree_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .code_bits    (code_bits),
    .code_length  (code_length),
    .symbol       (symbol),
    .bit_req      (bit_req),
    .done         (done),
    .status       (status),
    .found_symbol (found_symbol)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #(20 * 1000000);
    $display("testbench: FAIL");
    $finish;
  end

  // Empty the tree down to a bare root and park the cursor on it.
  task automatic tree_clear();
    for (int i = 0; i < MAX_NODES; i++) begin
      tree_l[i]    = '0;
      tree_r[i]    = '0;
      tree_sym[i]  = '0;
      tree_leaf[i] = 1'b0;
    end
    tree_fill  = CNT_W'(1);
    decode_pos = '0;
  endtask

  // Insert one code, creating missing inner nodes; undo on table overflow.
  task automatic tree_insert(input logic [CODE_W-1:0] bits, input int len,
                             input logic [SYM_W-1:0] sym,
                             output logic [ST_W-1:0] st, output logic [SYM_W-1:0] fs);
    idx_t cur;
    idx_t c;
    idx_t lpar;
    cnt_t first;
    bit   linked;
    bit   stop;
    bit   last;
    logic lbit;
    logic b;
    cur    = '0;
    lpar   = '0;
    lbit   = 1'b0;
    first  = tree_fill;
    linked = 1'b0;
    stop   = 1'b0;
    st     = ST_PRESENT;
    fs     = '0;
    for (int lv = 0; lv < len && !stop; lv++) begin
      b    = bits[len-1-lv];
      last = (lv == len - 1);
      if (tree_leaf[cur]) begin
        st   = ST_THRULEAF;
        stop = 1'b1;
      end else begin
        c = b ? tree_r[cur] : tree_l[cur];
        if (c != 0) begin
          if (last) begin
            st   = ST_PRESENT;
            stop = 1'b1;
          end else begin
            cur = c;
          end
        end else if (tree_fill >= MAX_NODES) begin
          // Drop everything this insert built by cutting its first new link.
          if (linked) begin
            if (lbit) tree_r[lpar] = '0;
            else tree_l[lpar] = '0;
          end
          tree_fill = first;
          st        = ST_FULL;
          stop      = 1'b1;
        end else begin
          c = tree_fill[IDX_W-1:0];
          tree_fill    = tree_fill + 1'b1;
          tree_l[c]    = '0;
          tree_r[c]    = '0;
          tree_leaf[c] = last;
          tree_sym[c]  = last ? sym : '0;
          if (b) tree_r[cur] = c;
          else tree_l[cur] = c;
          if (!linked) begin
            linked = 1'b1;
            lpar   = cur;
            lbit   = b;
          end
          cur = c;
        end
      end
    end
    if (!stop) begin
      if (tree_leaf[cur]) begin
        st = ST_OK;
        fs = tree_sym[cur];
      end else begin
        st = ST_PRESENT;
      end
    end
  endtask

  // Whole-code lookup from the root.
  task automatic tree_find(input logic [CODE_W-1:0] bits, input int len,
                           output logic [ST_W-1:0] st, output logic [SYM_W-1:0] fs);
    idx_t cur;
    idx_t c;
    bit   stop;
    cur  = '0;
    stop = 1'b0;
    st   = ST_PREFIX;
    fs   = '0;
    for (int lv = 0; lv < len && !stop; lv++) begin
      c = bits[len-1-lv] ? tree_r[cur] : tree_l[cur];
      if (c == 0) begin
        st   = ST_NOBRANCH;
        stop = 1'b1;
      end else begin
        cur = c;
      end
    end
    if (!stop && tree_leaf[cur]) begin
      st = ST_OK;
      fs = tree_sym[cur];
    end
  endtask

  // Work out the result of one transaction and update the table copy.
  task automatic tree_apply(input tree_cmd_t cmd, output tree_result_t res);
    idx_t c;
    res.st = ST_NOBRANCH;
    res.fs = '0;
    case (cmd.op)
      OP_INSERT: tree_insert(cmd.bits, int'(cmd.len), cmd.sym, res.st, res.fs);
      OP_FIND: tree_find(cmd.bits, int'(cmd.len), res.st, res.fs);
      OP_STEP: begin
        c = cmd.b ? tree_r[decode_pos] : tree_l[decode_pos];
        if (c != 0) begin
          decode_pos = c;
          if (tree_leaf[c]) begin
            res.st = ST_OK;
            res.fs = tree_sym[c];
          end else begin
            res.st = ST_PREFIX;
          end
        end
      end
      OP_CURSOR_RST: begin
        decode_pos = '0;
        res.st     = ST_OK;
      end
      OP_CLEAR: begin
        tree_clear();
        res.st = ST_OK;
      end
      default: ;
    endcase
    if (res.st != ST_OK) res.fs = '0;
  endtask

  function automatic tree_cmd_t make_cmd(logic [OP_W-1:0] op, logic [CODE_W-1:0] bits,
                                         logic [LEN_W-1:0] len, logic [SYM_W-1:0] sym,
                                         logic b);
    tree_cmd_t cmd;
    cmd.op    = op;
    cmd.bits  = bits;
    cmd.len   = len;
    cmd.sym   = sym;
    cmd.b     = b;
    cmd.typed = 1'b0;
    cmd.ex_st = '0;
    cmd.ex_fs = '0;
    return cmd;
  endfunction

  function automatic tree_cmd_t typed_cmd(logic [OP_W-1:0] op, logic [CODE_W-1:0] bits,
                                          logic [LEN_W-1:0] len, logic [SYM_W-1:0] sym,
                                          logic b, logic [ST_W-1:0] st,
                                          logic [SYM_W-1:0] fs);
    tree_cmd_t cmd;
    cmd       = make_cmd(op, bits, len, sym, b);
    cmd.typed = 1'b1;
    cmd.ex_st = st;
    cmd.ex_fs = fs;
    return cmd;
  endfunction

  // One of the operation codes the core ignores.
  function automatic logic [OP_W-1:0] OP_3BIT_SPARE();
    return OP_W'($urandom_range(OP_SPARE_A, OP_SPARE_C));
  endfunction

  // Present one transaction after a random idle gap and hold it until accepted.
  task automatic send_cmd(input tree_cmd_t cmd);
    tree_result_t res;
    int           gap;
    code_entry_t  ce;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 40) gap++;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start       <= 1'b1;
    operation   <= cmd.op;
    code_bits   <= cmd.bits;
    code_length <= cmd.len;
    symbol      <= cmd.sym;
    bit_req     <= cmd.b;
    do @(posedge clk); while (busy);
    tree_apply(cmd, res);
    if (cmd.typed) begin
      res.st = cmd.ex_st;
      res.fs = cmd.ex_fs;
    end
    pending_results.push_back(res);
    sent_count++;
    // Keep track of leaves so lookups and walks can target real codes.
    if (cmd.op == OP_INSERT && res.st == ST_OK) begin
      ce.bits = cmd.bits;
      ce.len  = cmd.len;
      known_codes.push_back(ce);
    end
    if (cmd.op == OP_CLEAR) known_codes.delete();
  endtask

  // Stop sending until every predicted result has come back.
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Reset the cursor and decode a known code (a random one if none is known) bit by bit, sometimes corrupted.
  task automatic walk_code();
    code_entry_t ce;
    logic        b;
    if (known_codes.size() == 0) begin
      ce.bits = CODE_W'($urandom);
      ce.len  = LEN_W'($urandom_range(1, 6));
    end else begin
      ce = known_codes[$urandom_range(known_codes.size() - 1)];
    end
    send_cmd(make_cmd(OP_CURSOR_RST, CODE_W'($urandom), LEN_W'($urandom), SYM_W'($urandom),
                      1'($urandom)));
    for (int i = int'(ce.len) - 1; i >= 0; i--) begin
      b = ce.bits[i];
      if ($urandom_range(99) < 8) b = ~b;
      send_cmd(make_cmd(OP_STEP, CODE_W'($urandom), LEN_W'($urandom), SYM_W'($urandom), b));
    end
    if ($urandom_range(99) < 30)
      send_cmd(make_cmd(OP_STEP, CODE_W'($urandom), LEN_W'($urandom), SYM_W'($urandom),
                        1'($urandom)));
  endtask

  // Compare every done strobe with the oldest prediction.
  always @(posedge clk) begin : check_results
    tree_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: status %0d, symbol %0d", $time, status,
                 found_symbol);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.st) begin
          $display("%0t status mismatch: expected %0d, actual %0d", $time, want.st, status);
          errors++;
        end
        if (found_symbol !== want.fs) begin
          $display("%0t found_symbol mismatch: expected %0d, actual %0d", $time, want.fs,
                   found_symbol);
          errors++;
        end
      end
    end
  end

  // Stimulus.
  initial begin : stimulus
    int  random_base;
    int  phase;
    int  new_phase;
    int  round_left;
    int  pick;
    int  len;
    bit  deep;
    code_entry_t ce;

    errors      = 0;
    sent_count  = 0;
    idle_pct    = 29;
    rst         = 1'b1;
    start       = 1'b0;
    operation   = OP_INSERT;
    code_bits   = '0;
    code_length = '0;
    symbol      = '0;
    bit_req     = 1'b0;
    tree_clear();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed transactions: empty tree, one-bit codes, leaves, full-length codes.
    directed_rows.push_back(typed_cmd(OP_FIND, 15'h0000, 4'd0, 9'd0, 1'b0, ST_PREFIX, 9'd0));
    directed_rows.push_back(typed_cmd(OP_STEP, 15'h0000, 4'd0, 9'd0, 1'b0, ST_NOBRANCH, 9'd0));
    directed_rows.push_back(typed_cmd(OP_INSERT, 15'h0000, 4'd0, 9'h1ff, 1'b0,
                                      ST_PRESENT, 9'd0));
    directed_rows.push_back(typed_cmd(OP_SPARE_A, 15'h7fff, 4'd15, 9'h1ff, 1'b1,
                                      ST_NOBRANCH, 9'd0));
    directed_rows.push_back(typed_cmd(OP_SPARE_C, 15'h7fff, 4'd15, 9'h1ff, 1'b1,
                                      ST_NOBRANCH, 9'd0));
    directed_rows.push_back(typed_cmd(OP_CURSOR_RST, 15'h0000, 4'd0, 9'd0, 1'b0, ST_OK, 9'd0));
    directed_rows.push_back(typed_cmd(OP_INSERT, 15'h0000, 4'd1, 9'd287, 1'b0, ST_OK, 9'd287));
    directed_rows.push_back(typed_cmd(OP_INSERT, 15'h0001, 4'd1, 9'd511, 1'b0, ST_OK, 9'd511));
    directed_rows.push_back(typed_cmd(OP_FIND, 15'h0000, 4'd1, 9'd0, 1'b0, ST_OK, 9'd287));
    directed_rows.push_back(typed_cmd(OP_INSERT, 15'h0000, 4'd2, 9'd3, 1'b0,
                                      ST_THRULEAF, 9'd0));
    directed_rows.push_back(typed_cmd(OP_INSERT, 15'h0000, 4'd1, 9'd4, 1'b0,
                                      ST_PRESENT, 9'd0));
    directed_rows.push_back(typed_cmd(OP_STEP, 15'h0000, 4'd0, 9'd0, 1'b1, ST_OK, 9'd511));
    directed_rows.push_back(typed_cmd(OP_STEP, 15'h0000, 4'd0, 9'd0, 1'b1, ST_NOBRANCH, 9'd0));
    directed_rows.push_back(make_cmd(OP_FIND, 15'h0003, 4'd2, 9'd0, 1'b0));
    directed_rows.push_back(typed_cmd(OP_CURSOR_RST, 15'h0000, 4'd0, 9'd0, 1'b0, ST_OK, 9'd0));
    directed_rows.push_back(typed_cmd(OP_CLEAR, 15'h7fff, 4'd15, 9'h1ff, 1'b1, ST_OK, 9'd0));
    directed_rows.push_back(typed_cmd(OP_FIND, 15'h0000, 4'd1, 9'd0, 1'b0, ST_NOBRANCH, 9'd0));
    directed_rows.push_back(typed_cmd(OP_INSERT, 15'h7fff, 4'd15, 9'd0, 1'b0, ST_OK, 9'd0));
    directed_rows.push_back(make_cmd(OP_FIND, 15'h3fff, 4'd14, 9'd0, 1'b0));
    directed_rows.push_back(make_cmd(OP_STEP, 15'h0000, 4'd0, 9'd0, 1'b1));
    directed_rows.push_back(make_cmd(OP_INSERT, 15'h7fff, 4'd15, 9'd5, 1'b0));
    directed_rows.push_back(make_cmd(OP_INSERT, 15'h3fff, 4'd14, 9'd9, 1'b0));
    directed_rows.push_back(make_cmd(OP_FIND, 15'h0000, 4'd15, 9'd0, 1'b0));
    directed_rows.push_back(make_cmd(OP_INSERT, 15'h0000, 4'd15, 9'h155, 1'b0));
    directed_rows.push_back(make_cmd(OP_CLEAR, 15'h0000, 4'd0, 9'd0, 1'b0));
    foreach (directed_rows[i]) send_cmd(directed_rows[i]);
    wait_drained();

    // Random rounds: each starts from a cleared tree and builds shallow or deep codes.
    random_base = sent_count;
    phase       = 0;
    round_left  = 0;
    deep        = 1'b0;
    while (sent_count - random_base < RANDOM_ITEMS) begin
      // Idling profile changes at thirds of the random part, with a full drain.
      new_phase = (sent_count - random_base) * 3 / RANDOM_ITEMS;
      if (new_phase != phase) begin
        wait_drained();
        phase    = new_phase;
        idle_pct = (phase == 1) ? 87 : 0;
      end
      if (round_left == 0) begin
        round_left = $urandom_range(40, 250);
        deep       = ($urandom_range(99) < 50);
        send_cmd(make_cmd(OP_CLEAR, CODE_W'($urandom), LEN_W'($urandom), SYM_W'($urandom),
                          1'($urandom)));
      end
      round_left--;
      pick = $urandom_range(99);
      if (pick < (deep ? 65 : 40)) begin
        // Insert a code of the round's depth, or of any length now and then.
        if ($urandom_range(99) < 10) len = $urandom_range(0, 15);
        else if (deep) len = $urandom_range(10, 15);
        else len = $urandom_range(1, 7);
        send_cmd(make_cmd(OP_INSERT, CODE_W'($urandom), LEN_W'(len), SYM_W'($urandom),
                          1'($urandom)));
      end else if (pick < 80) begin
        // Look up a known code, one of its prefixes, or something random.
        if (known_codes.size() != 0 && $urandom_range(99) < 70) begin
          ce = known_codes[$urandom_range(known_codes.size() - 1)];
          if ($urandom_range(99) < 30) begin
            len     = $urandom_range(0, ce.len);
            ce.bits = ce.bits >> (ce.len - len);
            ce.len  = LEN_W'(len);
          end
        end else begin
          ce.bits = CODE_W'($urandom);
          ce.len  = LEN_W'($urandom_range(0, 15));
        end
        send_cmd(make_cmd(OP_FIND, ce.bits, ce.len, SYM_W'($urandom), 1'($urandom)));
      end else if (pick < 93) begin
        walk_code();
      end else if (pick < 96) begin
        send_cmd(make_cmd(OP_STEP, CODE_W'($urandom), LEN_W'($urandom), SYM_W'($urandom),
                          1'($urandom)));
      end else if (pick < 98) begin
        send_cmd(make_cmd(OP_3BIT_SPARE(), CODE_W'($urandom), LEN_W'($urandom),
                          SYM_W'($urandom), 1'($urandom)));
      end else begin
        send_cmd(make_cmd(OP_CURSOR_RST, CODE_W'($urandom), LEN_W'($urandom),
                          SYM_W'($urandom), 1'($urandom)));
      end
    end

    // Let the last results come back, then keep watching for stray strobes.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/hct_pkg.sv
rtl/hct_ram.sv
rtl/hct_level.sv
rtl/huffman_code_tree_core.sv
tb/sv/testbench.sv
